FILE: rtl/srm_pkg.sv
// Shared types and constants for the six-register machine step block.
// Holds the opcode encoding, configuration register indexes and the index
// reduction helper. No dependencies.
package srm_pkg;

  // Number of registers in the file
  localparam int NUM_REGS = 6;

  // Register index width (covers indices 0..5)
  localparam int IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_IP_REGISTER    = 1'b0,
    CFG_PROGRAM_LENGTH = 1'b1
  } cfg_idx_t;

  // Instruction encoding
  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } opcode_t;

  // Reduce an 8-bit value modulo six: quotient by reciprocal 171/1024,
  // exact for all inputs below 256, then one multiply-subtract.
  function automatic logic [IDX_W-1:0] mod6(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  quot;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd171;
    quot = 8'(prod[15:10]);
    rem  = v - 8'(quot * 8'd6);
    return rem[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/srm_alu.sv
// Execution unit of the six-register machine: one instruction, one result.
// Purely combinational; depends on srm_pkg for the opcode encoding.
module srm_alu
  import srm_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  opcode_t                op,
  input  logic [7:0]             imm_a,
  input  logic [7:0]             imm_b,
  input  logic [DATA_WIDTH-1:0]  reg_a,
  input  logic [DATA_WIDTH-1:0]  reg_b,
  output logic [DATA_WIDTH-1:0]  result
);

  logic [DATA_WIDTH-1:0] ia;
  logic [DATA_WIDTH-1:0] ib;
  logic                  flag;

  // Zero-extend immediates to the data width
  assign ia = DATA_WIDTH'(imm_a);
  assign ib = DATA_WIDTH'(imm_b);

  // Select the operation; tests produce 0 or 1
  always_comb begin
    flag   = 1'b0;
    result = '0;
    case (op)
      OP_ADDR: result = reg_a + reg_b;
      OP_ADDI: result = reg_a + ib;
      OP_MULR: result = reg_a * reg_b;
      OP_MULI: result = reg_a * ib;
      OP_BANR: result = reg_a & reg_b;
      OP_BANI: result = reg_a & ib;
      OP_BORR: result = reg_a | reg_b;
      OP_BORI: result = reg_a | ib;
      OP_SETR: result = reg_a;
      OP_SETI: result = ia;
      OP_GTIR: begin
        flag   = $signed(ia) > $signed(reg_b);
        result = DATA_WIDTH'(flag);
      end
      OP_GTRI: begin
        flag   = $signed(reg_a) > $signed(ib);
        result = DATA_WIDTH'(flag);
      end
      OP_GTRR: begin
        flag   = $signed(reg_a) > $signed(reg_b);
        result = DATA_WIDTH'(flag);
      end
      OP_EQIR: begin
        flag   = (ia == reg_b);
        result = DATA_WIDTH'(flag);
      end
      OP_EQRI: begin
        flag   = (reg_a == ib);
        result = DATA_WIDTH'(flag);
      end
      OP_EQRR: begin
        flag   = (reg_a == reg_b);
        result = DATA_WIDTH'(flag);
      end
      default: result = '0;
    endcase
  end

endmodule

FILE: rtl/six_register_machine_step.sv
// Top level of the six-register machine step block.
// Depends on srm_pkg and srm_alu.
//
// Executes one instruction per transfer on six registers with the
// instruction pointer bound to the register selected by ip_register.
// Throughput is one instruction per clock: for an instruction in the
// input register, operand read, execute, register write-back and pointer
// update complete together, so the next instruction sees all effects of
// the previous one. It is held there only while the result register is
// full and not being drained. An instruction is captured in the input
// register on transfer and its result then goes to the result register,
// which drives out_valid. The result register decouples the two channels:
// a new instruction is taken while a result still waits. The user must
// write configuration only while no instruction is in flight; the block
// itself does not enforce it.
module six_register_machine_step
  import srm_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // instruction channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_opcode,
  input  logic [7:0]         in_operand_a,
  input  logic [7:0]         in_operand_b,
  input  logic [7:0]         in_dest_index,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_next_pointer,
  output logic               out_halted,
  output logic signed [31:0] out_written_value,
  output logic signed [31:0] out_register_zero,
  // configuration port
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int CMP_W = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;

  // configuration
  logic [IDX_W-1:0]      bound_r;
  logic [15:0]           plen_r;

  // architectural state
  logic [DATA_WIDTH-1:0] rf_r [NUM_REGS];
  logic [DATA_WIDTH-1:0] ip_r;
  logic [DATA_WIDTH-1:0] ip_nxt;

  // input stage
  logic                  in_vld_r;
  opcode_t               op_r;
  logic [7:0]            a_r;
  logic [7:0]            b_r;
  logic [IDX_W-1:0]      a_idx_r;
  logic [IDX_W-1:0]      b_idx_r;
  logic [IDX_W-1:0]      dst_r;

  // result stage
  logic                  out_vld_r;
  logic signed [31:0]    next_ptr_r;
  logic                  halted_r;
  logic signed [31:0]    wval_r;
  logic signed [31:0]    reg0_r;

  logic                  in_fire;
  logic                  advance;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] alu_val;
  logic [DATA_WIDTH-1:0] reg0_val;
  logic                  halted_nxt;
  logic [63:0]           next_ext;
  logic [63:0]           wval_ext;
  logic [63:0]           reg0_ext;

  // Handshake: the input stage moves on when the result register is free
  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | advance;
  assign in_fire  = in_valid & in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= '0;
      plen_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IP_REGISTER:    bound_r <= mod6({5'd0, cfg_wdata[2:0]});
        CFG_PROGRAM_LENGTH: plen_r  <= cfg_wdata;
        default:            plen_r  <= plen_r;
      endcase
    end
  end

  // Capture the instruction, reducing register indices up front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= opcode_t'(in_opcode);
      a_r     <= in_operand_a;
      b_r     <= in_operand_b;
      a_idx_r <= mod6(in_operand_a);
      b_idx_r <= mod6(in_operand_b);
      dst_r   <= mod6(in_dest_index);
    end
  end

  // Read operands; the bound register reads as the pointer
  assign rd_a = (a_idx_r == bound_r) ? ip_r : rf_r[a_idx_r];
  assign rd_b = (b_idx_r == bound_r) ? ip_r : rf_r[b_idx_r];

  srm_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .op     (op_r),
    .imm_a  (a_r),
    .imm_b  (b_r),
    .reg_a  (rd_a),
    .reg_b  (rd_b),
    .result (alu_val)
  );

  // Next pointer and register 0 after write-back
  assign ip_nxt   = ((dst_r == bound_r) ? alu_val : ip_r) + DATA_WIDTH'(1);
  assign reg0_val = (dst_r == IDX_W'(0))   ? alu_val :
                    (bound_r == IDX_W'(0)) ? ip_r    : rf_r[0];
  assign halted_nxt = ip_nxt[DATA_WIDTH-1] | (CMP_W'(ip_nxt) >= CMP_W'(plen_r));

  // Sign-extend results to the output width
  assign next_ext = 64'(signed'(ip_nxt));
  assign wval_ext = 64'(signed'(alu_val));
  assign reg0_ext = 64'(signed'(reg0_val));

  // Write back the destination and the bound register, advance the pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      ip_r <= '0;
    end else if (advance) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (dst_r == IDX_W'(i)) begin
          rf_r[i] <= alu_val;
        end else if (bound_r == IDX_W'(i)) begin
          rf_r[i] <= ip_r;
        end
      end
      ip_r <= ip_nxt;
    end
  end

  // Result register: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      next_ptr_r <= signed'(next_ext[31:0]);
      halted_r   <= halted_nxt;
      wval_r     <= signed'(wval_ext[31:0]);
      reg0_r     <= signed'(reg0_ext[31:0]);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_next_pointer  = next_ptr_r;
  assign out_halted        = halted_r;
  assign out_written_value = wval_r;
  assign out_register_zero = reg0_r;

endmodule
